/* sv/tlaid_pkg.sv */
`timescale 1ns / 1ps

package tlaid_pkg;

    // field widths
    localparam int ANGLE_W  = 16;
    localparam int RATE_W   = 24;
    localparam int COEF_W   = 18;
    localparam int TORQUE_W = 32;
    localparam int TRIG_W   = 18;
    localparam int CORDIC_W = 34;

    // cordic iterations, one pipeline stage each (8 to 24)
    localparam int CORDIC_STEPS = 16;

    // cordic constants in q.30
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_INERTIA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELBOW_INERTIA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING         = 2'd2;

    // coefficient reset values, q2.16
    localparam logic [COEF_W-1:0] SHOULDER_INERTIA_RST = 18'd30227;
    localparam logic [COEF_W-1:0] ELBOW_INERTIA_RST    = 18'd20901;
    localparam logic [COEF_W-1:0] COUPLING_RST         = 18'd20033;

    // joint rates and accelerations that ride along the cordic
    typedef struct packed {
        logic signed [RATE_W-1:0] elbow_accel;
        logic signed [RATE_W-1:0] shoulder_accel;
        logic signed [RATE_W-1:0] elbow_rate;
        logic signed [RATE_W-1:0] shoulder_rate;
    } motion_t;

    // one finished result
    typedef struct packed {
        logic                       saturated;
        logic signed [TORQUE_W-1:0] elbow_torque;
        logic signed [TORQUE_W-1:0] shoulder_torque;
    } result_t;

    // arctangent of 2^-i in q.30
    function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048576;
            11:      v = 34'sd524288;
            12:      v = 34'sd262144;
            13:      v = 34'sd131072;
            14:      v = 34'sd65536;
            15:      v = 34'sd32768;
            16:      v = 34'sd16384;
            17:      v = 34'sd8192;
            18:      v = 34'sd4096;
            19:      v = 34'sd2048;
            20:      v = 34'sd1024;
            21:      v = 34'sd512;
            22:      v = 34'sd256;
            23:      v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* sv/tlaid_cordic.sv */
`timescale 1ns / 1ps

module tlaid_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [tlaid_pkg::ANGLE_W-1:0] in_angle,
    input  tlaid_pkg::motion_t                   in_motion,
    output logic                                 out_valid,
    output logic signed [tlaid_pkg::TRIG_W-1:0]  out_cos,
    output logic signed [tlaid_pkg::TRIG_W-1:0]  out_sin,
    output tlaid_pkg::motion_t                   out_motion
);
    import tlaid_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_reg    [0:CORDIC_STEPS];
    logic                       flip_reg [0:CORDIC_STEPS];
    motion_t                    mot_reg  [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0]      vld_reg;

    logic signed [CORDIC_W-1:0] z_in;
    logic signed [CORDIC_W-1:0] z_next;
    logic                       flip_next;

    // fold the angle into the half turn around zero
    always_comb
    begin
        z_in      = CORDIC_W'(in_angle) <<< 17;
        z_next    = z_in;
        flip_next = 1'b0;
        if (z_in > HALF_PI_Q30)
        begin
            z_next    = z_in - PI_Q30;
            flip_next = 1'b1;
        end
        else if (z_in < -HALF_PI_Q30)
        begin
            z_next    = z_in + PI_Q30;
            flip_next = 1'b1;
        end
    end

    // valid bits of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[CORDIC_STEPS-1:0], in_valid};
        end
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
            mot_reg[0]  <= in_motion;
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_iter
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [CORDIC_W-1:0] x_next;
        logic signed [CORDIC_W-1:0] y_next;
        logic signed [CORDIC_W-1:0] zi_next;

        always_comb
        begin
            dx = y_reg[k] >>> k;
            dy = x_reg[k] >>> k;
            if (!z_reg[k][CORDIC_W-1])
            begin
                x_next  = x_reg[k] - dx;
                y_next  = y_reg[k] + dy;
                zi_next = z_reg[k] - atan_q30(k);
            end
            else
            begin
                x_next  = x_reg[k] + dx;
                y_next  = y_reg[k] - dy;
                zi_next = z_reg[k] + atan_q30(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= zi_next;
                flip_reg[k+1] <= flip_reg[k];
                mot_reg[k+1]  <= mot_reg[k];
            end
        end
    end

    // undo the half turn and round q.30 to q.16
    logic signed [CORDIC_W-1:0] xf;
    logic signed [CORDIC_W-1:0] yf;
    logic signed [CORDIC_W-1:0] xr;
    logic signed [CORDIC_W-1:0] yr;
    logic signed [TRIG_W-1:0]   cos_next;
    logic signed [TRIG_W-1:0]   sin_next;
    logic signed [TRIG_W-1:0]   cos_reg;
    logic signed [TRIG_W-1:0]   sin_reg;
    motion_t                    mot_out_reg;
    logic                       vld_out_reg;

    always_comb
    begin
        xf       = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        yf       = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        xr       = xf + 34'sd8192;
        yr       = yf + 34'sd8192;
        cos_next = $signed(xr[TRIG_W+13:14]);
        sin_next = $signed(yr[TRIG_W+13:14]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_out_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            mot_out_reg <= mot_reg[CORDIC_STEPS];
        end
    end

    assign out_valid  = vld_out_reg;
    assign out_cos    = cos_reg;
    assign out_sin    = sin_reg;
    assign out_motion = mot_out_reg;

endmodule

/* sv/tlaid_torque.sv */
`timescale 1ns / 1ps

module tlaid_torque (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [tlaid_pkg::TRIG_W-1:0] in_cos,
    input  logic signed [tlaid_pkg::TRIG_W-1:0] in_sin,
    input  tlaid_pkg::motion_t                  in_motion,
    input  logic [tlaid_pkg::COEF_W-1:0]        coef_shoulder_inertia,
    input  logic [tlaid_pkg::COEF_W-1:0]        coef_elbow_inertia,
    input  logic [tlaid_pkg::COEF_W-1:0]        coef_coupling,
    output logic                                out_valid,
    output tlaid_pkg::result_t                  out_result
);
    import tlaid_pkg::*;

    localparam int RSUM_W = 40;

    // clip to the torque range
    function automatic logic signed [TORQUE_W-1:0] sat_torque(
        input logic signed [RSUM_W-1:0] v);
        logic signed [TORQUE_W-1:0] r;
        if (v > RSUM_W'(signed'(32'sh7fffffff)))
            r = 32'sh7fffffff;
        else if (v < RSUM_W'(signed'(32'sh80000000)))
            r = 32'sh80000000;
        else
            r = v[TORQUE_W-1:0];
        return r;
    endfunction

    function automatic logic is_clipped(input logic signed [RSUM_W-1:0] v);
        return (v[RSUM_W-1:TORQUE_W-1] != '0) && (v[RSUM_W-1:TORQUE_W-1] != '1);
    endfunction

    logic signed [COEF_W:0] c1s;
    logic signed [COEF_W:0] c2s;
    logic signed [COEF_W:0] c3s;

    assign c1s = $signed({1'b0, coef_shoulder_inertia});
    assign c2s = $signed({1'b0, coef_elbow_inertia});
    assign c3s = $signed({1'b0, coef_coupling});

    logic [6:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:1], in_valid};
        end
    end

    // stage 1: rate products and acceleration sums
    logic signed [25:0]       sa_next, sa_reg;
    logic signed [24:0]       s12_next, s12_reg;
    logic signed [47:0]       pv22_next, pv22_reg;
    logic signed [47:0]       pv12_next, pv12_reg;
    logic signed [47:0]       pv11_next, pv11_reg;
    logic signed [RATE_W-1:0] a1_1_reg;
    logic signed [TRIG_W-1:0] cos_1_reg;
    logic signed [TRIG_W-1:0] sin_1_reg;

    always_comb
    begin
        sa_next   = (26'(in_motion.shoulder_accel) <<< 1) + 26'(in_motion.elbow_accel);
        s12_next  = 25'(in_motion.shoulder_accel) + 25'(in_motion.elbow_accel);
        pv22_next = in_motion.elbow_rate * in_motion.elbow_rate;
        pv12_next = in_motion.shoulder_rate * in_motion.elbow_rate;
        pv11_next = in_motion.shoulder_rate * in_motion.shoulder_rate;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg    <= sa_next;
            s12_reg   <= s12_next;
            pv22_reg  <= pv22_next;
            pv12_reg  <= pv12_next;
            pv11_reg  <= pv11_next;
            a1_1_reg  <= in_motion.shoulder_accel;
            cos_1_reg <= in_cos;
            sin_1_reg <= in_sin;
        end
    end

    // stage 2: round velocity terms, acceleration products
    logic signed [48:0]       w1_sum;
    logic signed [47:0]       w2_sum;
    logic signed [32:0]       w1_next, w1_reg;
    logic signed [31:0]       w2_next, w2_reg;
    logic signed [43:0]       pa_next, pa_reg;
    logic signed [41:0]       pb_next, pb_reg;
    logic signed [42:0]       k1_next, k1_reg;
    logic signed [43:0]       k2_next, k2_reg;
    logic signed [TRIG_W-1:0] sin_2_reg;

    always_comb
    begin
        w1_sum  = 49'(pv22_reg) + (49'(pv12_reg) <<< 1) + 49'sd32768;
        w2_sum  = pv11_reg + 48'sd32768;
        w1_next = $signed(w1_sum[48:16]);
        w2_next = $signed(w2_sum[47:16]);
        pa_next = sa_reg * cos_1_reg;
        pb_next = a1_1_reg * cos_1_reg;
        k1_next = c1s * a1_1_reg;
        k2_next = c2s * s12_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg    <= w1_next;
            w2_reg    <= w2_next;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            k1_reg    <= k1_next;
            k2_reg    <= k2_next;
            sin_2_reg <= sin_1_reg;
        end
    end

    // stage 3: velocity terms times sine, inertia sum
    logic signed [50:0] q1_next, q1_reg;
    logic signed [49:0] q2_next, q2_reg;
    logic signed [44:0] k12_next, k12_3_reg;
    logic signed [43:0] pa_3_reg;
    logic signed [41:0] pb_3_reg;
    logic signed [43:0] k2_3_reg;

    always_comb
    begin
        q1_next  = w1_reg * sin_2_reg;
        q2_next  = w2_reg * sin_2_reg;
        k12_next = 45'(k1_reg) + 45'(k2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg    <= q1_next;
            q2_reg    <= q2_next;
            k12_3_reg <= k12_next;
            pa_3_reg  <= pa_reg;
            pb_3_reg  <= pb_reg;
            k2_3_reg  <= k2_reg;
        end
    end

    // stage 4: trig terms rounded to q.16
    logic signed [51:0] d1_sum;
    logic signed [50:0] d2_sum;
    logic signed [35:0] t1_next, t1_reg;
    logic signed [34:0] t2_next, t2_reg;
    logic signed [44:0] k12_4_reg;
    logic signed [43:0] k2_4_reg;

    always_comb
    begin
        d1_sum  = 52'(pa_3_reg) - 52'(q1_reg) + 52'sd32768;
        d2_sum  = 51'(pb_3_reg) + 51'(q2_reg) + 51'sd32768;
        t1_next = $signed(d1_sum[51:16]);
        t2_next = $signed(d2_sum[50:16]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            k12_4_reg <= k12_3_reg;
            k2_4_reg  <= k2_3_reg;
        end
    end

    // stage 5: coupling products
    logic signed [54:0] m1_next, m1_reg;
    logic signed [53:0] m2_next, m2_reg;
    logic signed [44:0] k12_5_reg;
    logic signed [43:0] k2_5_reg;

    always_comb
    begin
        m1_next = c3s * t1_reg;
        m2_next = c3s * t2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            k12_5_reg <= k12_4_reg;
            k2_5_reg  <= k2_4_reg;
        end
    end

    // stage 6: final sums, rounding and clipping
    logic signed [55:0]       r1_sum;
    logic signed [54:0]       r2_sum;
    logic signed [RSUM_W-1:0] r1;
    logic signed [RSUM_W-1:0] r2;
    result_t                  res_next, res_reg;

    always_comb
    begin
        r1_sum                   = 56'(k12_5_reg) + 56'(m1_reg) + 56'sd32768;
        r2_sum                   = 55'(k2_5_reg) + 55'(m2_reg) + 55'sd32768;
        r1                       = $signed(r1_sum[55:16]);
        r2                       = RSUM_W'($signed(r2_sum[54:16]));
        res_next.shoulder_torque = sat_torque(r1);
        res_next.elbow_torque    = sat_torque(r2);
        res_next.saturated       = is_clipped(r1) | is_clipped(r2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = vld_reg[6];
    assign out_result = res_reg;

endmodule

/* sv/two_link_arm_inverse_dynamics.sv */
// Inverse dynamics of a two-link planar arm: each request carries the elbow angle (q3.13),
// both joint rates and both joint accelerations (q7.16), and yields both joint torques
// (q15.16, saturated) plus a clip flag. The block takes one request per clock and returns
// one result per clock while the result side keeps up; the path runs through the sine/cosine
// CORDIC with one micro-rotation per pipeline stage, followed by a six-stage multiply-add
// pipeline and the output register. When the result side stalls, one further result is held
// in a skid register and s_axis_tready then drops until that result moves to the output;
// nothing in flight is lost. The three inertia coefficients (q2.16) are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no request is in flight,
// as the block does not enforce this. They reset to their nominal values.
`timescale 1ns / 1ps

module two_link_arm_inverse_dynamics (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // elbow_angle, shoulder_rate, elbow_rate, shoulder_accel, elbow_accel
    input  logic [111:0]                          s_axis_tdata,
    // result channel
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // shoulder_torque, elbow_torque
    output logic [63:0]                           m_axis_tdata,
    // saturated
    output logic [0:0]                            m_axis_tuser,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [tlaid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlaid_pkg::COEF_W-1:0]          cfg_data
);
    import tlaid_pkg::*;

    // coefficient registers
    logic [COEF_W-1:0] coef_shoulder_inertia_reg;
    logic [COEF_W-1:0] coef_elbow_inertia_reg;
    logic [COEF_W-1:0] coef_coupling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_shoulder_inertia_reg <= SHOULDER_INERTIA_RST;
            coef_elbow_inertia_reg    <= ELBOW_INERTIA_RST;
            coef_coupling_reg         <= COUPLING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHOULDER_INERTIA: coef_shoulder_inertia_reg <= cfg_data;
                REG_ELBOW_INERTIA:    coef_elbow_inertia_reg    <= cfg_data;
                REG_COUPLING:         coef_coupling_reg         <= cfg_data;
                default:              ;
            endcase
        end
    end

    // unpack the request
    logic signed [ANGLE_W-1:0] in_angle;
    motion_t                   in_motion;

    assign in_angle                 = $signed(s_axis_tdata[15:0]);
    assign in_motion.shoulder_rate  = $signed(s_axis_tdata[39:16]);
    assign in_motion.elbow_rate     = $signed(s_axis_tdata[63:40]);
    assign in_motion.shoulder_accel = $signed(s_axis_tdata[87:64]);
    assign in_motion.elbow_accel    = $signed(s_axis_tdata[111:88]);

    // pipeline advances while the skid register is free
    logic skid_valid_reg;
    logic advance;

    assign advance       = ~skid_valid_reg;
    assign s_axis_tready = advance;

    logic                     cor_valid;
    logic signed [TRIG_W-1:0] cor_cos;
    logic signed [TRIG_W-1:0] cor_sin;
    motion_t                  cor_motion;

    tlaid_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (s_axis_tvalid),
        .in_angle   (in_angle),
        .in_motion  (in_motion),
        .out_valid  (cor_valid),
        .out_cos    (cor_cos),
        .out_sin    (cor_sin),
        .out_motion (cor_motion)
    );

    logic    pipe_valid;
    result_t pipe_result;

    tlaid_torque u_torque (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .en                    (advance),
        .in_valid              (cor_valid),
        .in_cos                (cor_cos),
        .in_sin                (cor_sin),
        .in_motion             (cor_motion),
        .coef_shoulder_inertia (coef_shoulder_inertia_reg),
        .coef_elbow_inertia    (coef_elbow_inertia_reg),
        .coef_coupling         (coef_coupling_reg),
        .out_valid             (pipe_valid),
        .out_result            (pipe_result)
    );

    // output register with skid stage
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    always_comb
    begin
        take            = out_valid_reg & m_axis_tready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else
        begin
            if (take)
            begin
                out_valid_next = 1'b0;
            end
            if (pipe_valid)
            begin
                if (!out_valid_reg || take)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pipe_result;
                end
                else
                begin
                    skid_valid_next = 1'b1;
                    skid_data_next  = pipe_result;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // pack the result
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.elbow_torque, out_data_reg.shoulder_torque};
    assign m_axis_tuser  = out_data_reg.saturated;

endmodule

/* sim/two_link_arm_inverse_dynamics_tb.sv */
`timescale 1ns / 1ps

module two_link_arm_inverse_dynamics_tb;

    localparam int CLK_HALF     = 4;
    localparam int PIPE_LATENCY = tlaid_pkg::CORDIC_STEPS + 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 215;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_ROWS     = 24;

    // index that maps to no register, writes to it are dropped
    localparam logic [tlaid_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [17:0] COEF_MAX          = 18'h3ffff;
    localparam logic [17:0] SHOULDER_NOMINAL  = 18'd30227;
    localparam logic [17:0] ELBOW_NOMINAL     = 18'd20901;
    localparam logic [17:0] COUPLING_NOMINAL  = 18'd20033;

    localparam int RATE_MAX = 8388607;
    localparam int RATE_MIN = -8388608;
    localparam logic signed [31:0] TORQUE_TOP    = 32'sh7fffffff;
    localparam logic signed [31:0] TORQUE_BOTTOM = 32'sh80000000;

    // cordic numbers in q.30
    localparam longint GAIN_Q30      = 652032874;
    localparam longint HALF_TURN_Q30 = 64'sd3373259426;
    localparam longint QUARTER_Q30   = 1686629713;
    localparam longint SAT_HIGH      = 64'sd2147483647;
    localparam longint SAT_LOW       = -64'sd2147483648;

    longint arctan_q30 [24] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    // one request, packed so that elbow_angle lands in the low bits of tdata
    typedef struct packed {
        logic signed [23:0] elbow_accel;
        logic signed [23:0] shoulder_accel;
        logic signed [23:0] elbow_rate;
        logic signed [23:0] shoulder_rate;
        logic signed [15:0] elbow_angle;
    } arm_request_t;

    typedef struct packed {
        logic               max_coefs;
        logic               typed;
        logic signed [31:0] shoulder_torque;
        logic signed [31:0] elbow_torque;
        logic               saturated;
        arm_request_t       req;
    } directed_row_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} ready_pattern_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [111:0]                        s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [63:0]                         m_axis_tdata;
    logic [0:0]                          m_axis_tuser;
    logic                                cfg_we = 1'b0;
    logic [tlaid_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [tlaid_pkg::COEF_W-1:0]        cfg_data = '0;

    // coefficient copies as the block should hold them
    logic [17:0] coef_shoulder = SHOULDER_NOMINAL;
    logic [17:0] coef_elbow    = ELBOW_NOMINAL;
    logic [17:0] coef_coupling = COUPLING_NOMINAL;

    tlaid_pkg::result_t torque_queue [$];
    int             mismatches = 0;
    int             results_seen = 0;
    int             cycle_count = 0;
    int             hold_left = 0;
    logic           hold_done = 1'b0;
    ready_pattern_t ready_mode = READY_ALWAYS;
    int             mode_cycles = 0;
    int             pattern_phase = 0;

    // fields: max_coefs, typed, shoulder, elbow, saturated,
    // then the request from elbow_accel down to elbow_angle
    directed_row_t directed_rows [NUM_ROWS] = '{
        '{1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, 0, 0}},
        '{1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, 0, 25736}},
        '{1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, 0, -25736}},
        '{1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, 0, 32767}},
        '{1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, 0, -32768}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{0, RATE_MAX, 0, 0, 0}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{0, RATE_MIN, 0, 0, 0}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{RATE_MAX, 0, 0, 0, 6434}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{RATE_MIN, 0, 0, 0, -6434}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, RATE_MAX, 12868}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, RATE_MIN, -12868}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{0, 0, RATE_MAX, 0, 12867}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{0, 0, RATE_MIN, 0, -12867}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0,
          '{RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX, 25736}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0,
          '{RATE_MIN, RATE_MIN, RATE_MIN, RATE_MIN, -25736}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{65536, 65536, 65536, 65536, 6434}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, '{-1, -1, -1, -1, 1}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0,
          '{RATE_MIN, RATE_MAX, RATE_MIN, RATE_MAX, 32767}},
        '{1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0,
          '{RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX, -32768}},
        // huge rates with large coupling clip both torques
        '{1'b1, 1'b1, TORQUE_BOTTOM, TORQUE_TOP, 1'b1,
          '{0, 0, RATE_MAX, RATE_MAX, 12000}},
        '{1'b1, 1'b1, TORQUE_TOP, TORQUE_BOTTOM, 1'b1,
          '{0, 0, RATE_MAX, RATE_MAX, -12000}},
        '{1'b1, 1'b1, 32'sd0, 32'sd0, 1'b0, '{0, 0, 0, 0, 0}},
        '{1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0,
          '{RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX, 0}},
        '{1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0,
          '{RATE_MIN, RATE_MIN, RATE_MIN, RATE_MIN, 25736}}
    };

    two_link_arm_inverse_dynamics dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clip_torque(input longint v, inout logic clipped);
        if (v > SAT_HIGH)
        begin
            clipped = 1'b1;
            return SAT_HIGH;
        end
        if (v < SAT_LOW)
        begin
            clipped = 1'b1;
            return SAT_LOW;
        end
        return v;
    endfunction

    // joint torques for one request under the current coefficients
    function automatic tlaid_pkg::result_t predict_torques(input arm_request_t req);
        longint z, x, y, dx, dy, cos_q16, sin_q16;
        longint v1, v2, a1, a2, k1, k2, k3;
        longint w1, t1, w2, t2, tau1, tau2;
        logic   flip;
        logic   clipped;
        tlaid_pkg::result_t r;
        z = longint'(req.elbow_angle) * 131072;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        clipped = 1'b0;
        // half-turn fold into the cordic range
        if (z > QUARTER_Q30)
        begin
            z = z - HALF_TURN_Q30;
            flip = 1'b1;
        end
        else if (z < -QUARTER_Q30)
        begin
            z = z + HALF_TURN_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < tlaid_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q30[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q30[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q16 = (x + 8192) >>> 14;
        sin_q16 = (y + 8192) >>> 14;

        v1 = longint'(req.shoulder_rate);
        v2 = longint'(req.elbow_rate);
        a1 = longint'(req.shoulder_accel);
        a2 = longint'(req.elbow_accel);
        k1 = longint'(coef_shoulder);
        k2 = longint'(coef_elbow);
        k3 = longint'(coef_coupling);

        // shoulder: inertia terms plus coupling with velocity products
        w1 = round_q16(v2 * v2 + 2 * v1 * v2);
        t1 = round_q16((2 * a1 + a2) * cos_q16 - w1 * sin_q16);
        tau1 = clip_torque(round_q16(k1 * a1 + k2 * (a1 + a2) + k3 * t1), clipped);

        // elbow
        w2 = round_q16(v1 * v1);
        t2 = round_q16(a1 * cos_q16 + w2 * sin_q16);
        tau2 = clip_torque(round_q16(k2 * (a1 + a2) + k3 * t2), clipped);

        r.shoulder_torque = tau1[31:0];
        r.elbow_torque = tau2[31:0];
        r.saturated = clipped;
        return r;
    endfunction

    function automatic logic signed [23:0] corner_rate();
        case ($urandom_range(0, 4))
            0: return RATE_MAX;
            1: return RATE_MIN;
            2: return 24'sd0;
            3: return -24'sd1;
            default: return 24'sd1;
        endcase
    endfunction

    // random request: full range, moderate, small or corner values
    function automatic arm_request_t make_request();
        arm_request_t req;
        int           kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            req.elbow_angle    = 16'($urandom);
            req.shoulder_rate  = 24'($urandom);
            req.elbow_rate     = 24'($urandom);
            req.shoulder_accel = 24'($urandom);
            req.elbow_accel    = 24'($urandom);
        end
        else if (kind <= 6)
        begin
            req.elbow_angle    = 16'(int'($urandom_range(0, 51472)) - 25736);
            req.shoulder_rate  = 24'(int'($urandom_range(0, 2097152)) - 1048576);
            req.elbow_rate     = 24'(int'($urandom_range(0, 2097152)) - 1048576);
            req.shoulder_accel = 24'(int'($urandom_range(0, 2097152)) - 1048576);
            req.elbow_accel    = 24'(int'($urandom_range(0, 2097152)) - 1048576);
        end
        else if (kind <= 8)
        begin
            req.elbow_angle    = 16'(int'($urandom_range(0, 51472)) - 25736);
            req.shoulder_rate  = 24'(int'($urandom_range(0, 8192)) - 4096);
            req.elbow_rate     = 24'(int'($urandom_range(0, 8192)) - 4096);
            req.shoulder_accel = 24'(int'($urandom_range(0, 8192)) - 4096);
            req.elbow_accel    = 24'(int'($urandom_range(0, 8192)) - 4096);
        end
        else
        begin
            req.elbow_angle    = 16'($urandom);
            req.shoulder_rate  = corner_rate();
            req.elbow_rate     = corner_rate();
            req.shoulder_accel = corner_rate();
            req.elbow_accel    = corner_rate();
        end
        return req;
    endfunction

    // offer one request and queue its expected torques once taken
    task automatic push_request(input arm_request_t req, input logic typed,
                                input tlaid_pkg::result_t known);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
            torque_queue.push_back(known);
        else
            torque_queue.push_back(predict_torques(req));
    endtask

    // wait until every expected result is back and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (torque_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic program_coefs(input logic [17:0] shoulder, input logic [17:0] elbow,
                                 input logic [17:0] coupling, input logic [17:0] unused);
        cfg_we    <= 1'b1;
        cfg_index <= tlaid_pkg::REG_SHOULDER_INERTIA;
        cfg_data  <= shoulder;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= unused;
        @(posedge clk);
        cfg_index <= tlaid_pkg::REG_ELBOW_INERTIA;
        cfg_data  <= elbow;
        @(posedge clk);
        cfg_index <= tlaid_pkg::REG_COUPLING;
        cfg_data  <= coupling;
        @(posedge clk);
        cfg_we <= 1'b0;
        coef_shoulder = shoulder;
        coef_elbow    = elbow;
        coef_coupling = coupling;
    endtask

    // random requests in bursts with random gaps
    task automatic run_random(input int count);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++)
        begin
            push_request(make_request(), 1'b0, '0);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // result side: changing stall patterns, plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_cycles == 0)
            begin
                ready_mode  = ready_pattern_t'($urandom_range(0, 3));
                mode_cycles = $urandom_range(16, 96);
            end
            else
                mode_cycles = mode_cycles - 1;
            pattern_phase = (pattern_phase + 1) % 4;
            case (ready_mode)
                READY_ALWAYS:   m_axis_tready <= 1'b1;
                READY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                READY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 9) != 0);
                default:        m_axis_tready <= (pattern_phase != 3);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        tlaid_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (torque_queue.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d %0d %0b", $time,
                         $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                         m_axis_tuser[0]);
                mismatches++;
            end
            else
            begin
                want = torque_queue.pop_front();
                if (m_axis_tdata[31:0] !== want.shoulder_torque)
                begin
                    $display("%0t: shoulder_torque: expected %0d, actual %0d", $time,
                             want.shoulder_torque, $signed(m_axis_tdata[31:0]));
                    mismatches++;
                end
                if (m_axis_tdata[63:32] !== want.elbow_torque)
                begin
                    $display("%0t: elbow_torque: expected %0d, actual %0d", $time,
                             want.elbow_torque, $signed(m_axis_tdata[63:32]));
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.saturated)
                begin
                    $display("%0t: saturated: expected %0b, actual %0b", $time,
                             want.saturated, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("two_link_arm_inverse_dynamics_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        tlaid_pkg::result_t known;
        logic               at_max;
        at_max = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].max_coefs && !at_max)
            begin
                settle();
                program_coefs(COEF_MAX, COEF_MAX, COEF_MAX, 18'($urandom));
                at_max = 1'b1;
            end
            known.shoulder_torque = directed_rows[i].shoulder_torque;
            known.elbow_torque    = directed_rows[i].elbow_torque;
            known.saturated       = directed_rows[i].saturated;
            push_request(directed_rows[i].req, directed_rows[i].typed, known);
        end

        // random phases over several coefficient settings
        run_random(110);
        settle();
        program_coefs(18'd0, 18'd0, 18'd0, 18'($urandom));
        run_random(60);
        settle();
        program_coefs(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
        run_random(130);
        settle();
        program_coefs(18'($urandom), 18'($urandom), 18'($urandom), COEF_MAX);
        run_random(110);
        settle();
        program_coefs(SHOULDER_NOMINAL, ELBOW_NOMINAL, COUPLING_NOMINAL, 18'd0);
        run_random(40);
        settle();

        if (mismatches == 0)
            $display("two_link_arm_inverse_dynamics_tb: PASS");
        else
            $display("two_link_arm_inverse_dynamics_tb: FAIL");
        $finish;
    end

endmodule
